[hdl/kcews_pkg.sv]
// Shared types and constants for the cycle-edge weight sum block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package kcews_pkg;

  localparam int NODE_W   = 10;
  localparam int NODES    = 1024;
  localparam int RANK_W   = 4;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 48;

  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // front request queue
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  typedef struct packed {
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                in_range;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

  typedef struct packed {
    logic pop;   // engine takes the head request
    logic hold;  // store clear in progress, refuse new requests
  } eng_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_UNION,
    ST_EMIT
  } eng_state_e;

endpackage

[hdl/kruskal_cycle_edge_weight_sum_top.sv]
// Top level of the cycle-edge weight sum block: front request queue plus
// union-find engine. Depends on kcews_pkg, kcews_front and kcews_engine.
`timescale 1ns / 1ps

// Edge filter for a maximum spanning tree built the Kruskal way. Push one
// edge per request (two node indices and an unsigned Q16.16 weight), heaviest
// first. The block tracks connected components in a union-find store (parent
// link and 4-bit rank per node, union by rank). An edge whose endpoints are
// already joined - a self loop included - closes a cycle: closed_cycle_o is 1
// and its weight is added to a Q32.16 total that saturates at all ones. Any
// other edge merges two components. An endpoint at or above the node count
// leaves everything unchanged and reports 0 with the current total. Exactly
// one result comes out per request, in order, on a queue-style port: the
// result is valid while empty is low and is taken with pop.
// After reset the store is cleared one node per cycle, with full held high.
// After that the engine walks from each endpoint of a request in turn up to
// its root, then merges or adds in a union step and loads the result
// register; each step of a root walk is one registered read of the parent
// memory. Union by rank keeps the depth of a node below its root at 10 or
// less. A two-entry queue in front and the result register behind let
// pushes and pops proceed while the engine works.

module kruskal_cycle_edge_weight_sum_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [kcews_pkg::NODE_W-1:0]    node_a_i,
  input  logic [kcews_pkg::NODE_W-1:0]    node_b_i,
  input  logic [kcews_pkg::WEIGHT_W-1:0]  weight_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            closed_cycle_o,
  output logic [kcews_pkg::TOTAL_W-1:0]   dropped_total_o
);

  kcews_pkg::req_chan_t req;
  kcews_pkg::eng_ctl_t  ctl;

  // front: range check and short request queue
  kcews_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .node_a_i (node_a_i),
    .node_b_i (node_b_i),
    .weight_i (weight_i),
    .ctl_i    (ctl),
    .req_o    (req)
  );

  // back: root walks, union, total and result register
  kcews_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .ctl_o           (ctl),
    .pop             (pop),
    .empty           (empty),
    .closed_cycle_o  (closed_cycle_o),
    .dropped_total_o (dropped_total_o)
  );

endmodule

[hdl/kcews_front.sv]
// Front end: accepts edge requests, range-checks the endpoints and queues them.
// Depends on kcews_pkg.
`timescale 1ns / 1ps

module kcews_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [kcews_pkg::NODE_W-1:0]  node_a_i,
  input  logic [kcews_pkg::NODE_W-1:0]  node_b_i,
  input  logic [kcews_pkg::WEIGHT_W-1:0] weight_i,
  input  kcews_pkg::eng_ctl_t           ctl_i,
  output kcews_pkg::req_chan_t          req_o
);

  kcews_pkg::req_t                     slots_q [kcews_pkg::FQ_DEPTH];
  kcews_pkg::req_t                     new_req;
  logic [kcews_pkg::FQ_PTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [kcews_pkg::FQ_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                push_ok, pop_ok;

  assign full    = (cnt_q == kcews_pkg::FQ_CNT_W'(kcews_pkg::FQ_DEPTH)) || ctl_i.hold;
  assign push_ok = push && !full;
  assign pop_ok  = ctl_i.pop && (cnt_q != '0);

  always_comb begin
    new_req.node_a   = node_a_i;
    new_req.node_b   = node_b_i;
    new_req.weight   = weight_i;
    new_req.in_range =
      ({1'b0, node_a_i} < (kcews_pkg::NODE_W + 1)'(kcews_pkg::NODES)) &&
      ({1'b0, node_b_i} < (kcews_pkg::NODE_W + 1)'(kcews_pkg::NODES));
  end

  always_comb begin
    wr_d  = push_ok ? wr_q + kcews_pkg::FQ_PTR_W'(1) : wr_q;
    rd_d  = pop_ok  ? rd_q + kcews_pkg::FQ_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + kcews_pkg::FQ_CNT_W'(push_ok) - kcews_pkg::FQ_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slots_q[wr_q] <= new_req;
    end
  end

  assign req_o.valid = (cnt_q != '0);
  assign req_o.req   = slots_q[rd_q];

endmodule

[hdl/kcews_engine.sv]
// Back end: union-find store, root walks, union by rank, saturating total
// and the result register. Depends on kcews_pkg.
`timescale 1ns / 1ps

module kcews_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kcews_pkg::req_chan_t           req_i,
  output kcews_pkg::eng_ctl_t            ctl_o,
  input  logic                           pop,
  output logic                           empty,
  output logic                           closed_cycle_o,
  output logic [kcews_pkg::TOTAL_W-1:0]  dropped_total_o
);

  // union-find store
  logic [kcews_pkg::NODE_W-1:0] parent_mem [kcews_pkg::NODES];
  logic [kcews_pkg::RANK_W-1:0] rank_mem   [kcews_pkg::NODES];

  logic [kcews_pkg::NODE_W-1:0] rd_addr;
  logic [kcews_pkg::NODE_W-1:0] par_rd_q;
  logic [kcews_pkg::RANK_W-1:0] rank_rd_q;
  logic                         par_we, rank_we;
  logic [kcews_pkg::NODE_W-1:0] par_wa, par_wd, rank_wa;
  logic [kcews_pkg::RANK_W-1:0] rank_wd;

  kcews_pkg::eng_state_e          state_q, state_d;
  logic [kcews_pkg::NODE_W-1:0]   clr_q, clr_d;
  logic [kcews_pkg::NODE_W-1:0]   cur_q, cur_d;
  logic [kcews_pkg::NODE_W-1:0]   b_q, b_d;
  logic [kcews_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic [kcews_pkg::NODE_W-1:0]   root_a_q, root_a_d, root_b_q, root_b_d;
  logic [kcews_pkg::RANK_W-1:0]   rank_a_q, rank_a_d, rank_b_q, rank_b_d;
  logic                           closed_q, closed_d;
  logic [kcews_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [kcews_pkg::TOTAL_W:0]    sum;

  logic                           out_load;
  logic                           out_valid_q, out_valid_d;
  logic                           out_closed_q;
  logic [kcews_pkg::TOTAL_W-1:0]  out_total_q;
  logic                           pop_ok;

  assign pop_ok = pop && out_valid_q;
  assign sum    = {1'b0, total_q} + (kcews_pkg::TOTAL_W + 1)'(w_q);

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      parent_mem[par_wa] <= par_wd;
    end
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    par_rd_q  <= parent_mem[rd_addr];
    rank_rd_q <= rank_mem[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    b_d       = b_q;
    w_d       = w_q;
    root_a_d  = root_a_q;
    rank_a_d  = rank_a_q;
    root_b_d  = root_b_q;
    rank_b_d  = rank_b_q;
    closed_d  = closed_q;
    total_d   = total_q;
    rd_addr   = cur_q;
    par_we    = 1'b0;
    par_wa    = root_a_q;
    par_wd    = root_b_q;
    rank_we   = 1'b0;
    rank_wa   = root_a_q;
    rank_wd   = rank_a_q + kcews_pkg::RANK_W'(1);
    out_load  = 1'b0;
    ctl_o.pop  = 1'b0;
    ctl_o.hold = (state_q == kcews_pkg::ST_CLEAR);

    unique case (state_q)
      kcews_pkg::ST_CLEAR: begin
        par_we  = 1'b1;
        par_wa  = clr_q;
        par_wd  = clr_q;
        rank_we = 1'b1;
        rank_wa = clr_q;
        rank_wd = '0;
        clr_d   = clr_q + kcews_pkg::NODE_W'(1);
        if (clr_q == kcews_pkg::NODE_W'(kcews_pkg::NODES - 1)) begin
          state_d = kcews_pkg::ST_IDLE;
        end
      end
      kcews_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          ctl_o.pop = 1'b1;
          cur_d     = req_i.req.node_a;
          rd_addr   = req_i.req.node_a;
          b_d       = req_i.req.node_b;
          w_d       = req_i.req.weight;
          closed_d  = 1'b0;
          state_d   = req_i.req.in_range ? kcews_pkg::ST_FIND_A : kcews_pkg::ST_EMIT;
        end
      end
      kcews_pkg::ST_FIND_A: begin
        if (par_rd_q == cur_q) begin
          root_a_d = cur_q;
          rank_a_d = rank_rd_q;
          cur_d    = b_q;
          rd_addr  = b_q;
          state_d  = kcews_pkg::ST_FIND_B;
        end else begin
          cur_d   = par_rd_q;
          rd_addr = par_rd_q;
        end
      end
      kcews_pkg::ST_FIND_B: begin
        if (par_rd_q == cur_q) begin
          root_b_d = cur_q;
          rank_b_d = rank_rd_q;
          state_d  = kcews_pkg::ST_UNION;
        end else begin
          cur_d   = par_rd_q;
          rd_addr = par_rd_q;
        end
      end
      kcews_pkg::ST_UNION: begin
        priority if (root_a_q == root_b_q) begin
          closed_d = 1'b1;
          total_d  = sum[kcews_pkg::TOTAL_W] ? kcews_pkg::TOTAL_MAX
                                             : sum[kcews_pkg::TOTAL_W-1:0];
        end else if (rank_a_q < rank_b_q) begin
          par_we = 1'b1;
          par_wa = root_a_q;
          par_wd = root_b_q;
        end else begin
          par_we = 1'b1;
          par_wa = root_b_q;
          par_wd = root_a_q;
          // ranks tie: the surviving root grows, capped at the rank ceiling
          if ((rank_a_q == rank_b_q) && (rank_a_q != kcews_pkg::RANK_MAX)) begin
            rank_we = 1'b1;
          end
        end
        state_d = kcews_pkg::ST_EMIT;
      end
      kcews_pkg::ST_EMIT: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = kcews_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kcews_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_ok) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kcews_pkg::ST_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    b_q      <= b_d;
    w_q      <= w_d;
    root_a_q <= root_a_d;
    rank_a_q <= rank_a_d;
    root_b_q <= root_b_d;
    rank_b_q <= rank_b_d;
    closed_q <= closed_d;
    if (out_load) begin
      out_closed_q <= closed_q;
      out_total_q  <= total_q;
    end
  end

  assign empty           = !out_valid_q;
  assign closed_cycle_o  = out_closed_q;
  assign dropped_total_o = out_total_q;

endmodule

[dv/tb_kruskal_cycle_edge_weight_sum_top.sv]
// Testbench for kruskal_cycle_edge_weight_sum_top: streams edges and checks each
// cycle flag and running total against an in-bench union-find predictor.
// Depends on kcews_pkg and the block's RTL under hdl/.
`timescale 1ns / 1ps

module tb_kruskal_cycle_edge_weight_sum_top;

  localparam int RANDOM_EDGES = 1050;
  localparam int CYCLE_LIMIT  = 400000;  // room for the store clear and every request
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_PCT     = 35;
  localparam int STEADY_LO    = 300;     // no idling while the accepted count is in here
  localparam int STEADY_HI    = 560;

  typedef struct packed {
    logic [kcews_pkg::NODE_W-1:0]   a;
    logic [kcews_pkg::NODE_W-1:0]   b;
    logic [kcews_pkg::WEIGHT_W-1:0] w;
  } edge_req_t;

  typedef struct packed {
    logic                          closed;
    logic [kcews_pkg::TOTAL_W-1:0] total;
  } cycle_result_t;

  logic                           clk_i  = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           push   = 1'b0;
  logic                           pop    = 1'b0;
  logic [kcews_pkg::NODE_W-1:0]   node_a_i = '0;
  logic [kcews_pkg::NODE_W-1:0]   node_b_i = '0;
  logic [kcews_pkg::WEIGHT_W-1:0] weight_i = '0;
  logic                           full;
  logic                           empty;
  logic                           closed_cycle_o;
  logic [kcews_pkg::TOTAL_W-1:0]  dropped_total_o;

  kruskal_cycle_edge_weight_sum_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .weight_i        (weight_i),
    .empty           (empty),
    .pop             (pop),
    .closed_cycle_o  (closed_cycle_o),
    .dropped_total_o (dropped_total_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: union-find forest mirrored in the bench. Compression in the
  // root walk keeps it fast and cannot change any flag or total.
  // ---------------------------------------------------------------------------
  logic [kcews_pkg::NODE_W-1:0]  up_link   [kcews_pkg::NODES];
  logic [kcews_pkg::RANK_W-1:0]  comp_rank [kcews_pkg::NODES];
  logic [kcews_pkg::TOTAL_W-1:0] cycle_sum;

  edge_req_t     edge_q[$];            // requests waiting for the driver
  cycle_result_t cycle_results_q[$];   // predicted results, oldest first

  int n_taken   = 0;   // requests accepted by the block
  int n_errors  = 0;
  int cyc_cnt   = 0;
  logic [kcews_pkg::WEIGHT_W-1:0] desc_weight = '1;

  wire steady = (n_taken >= STEADY_LO) && (n_taken < STEADY_HI);

  function automatic logic [kcews_pkg::NODE_W-1:0] root_of(
    logic [kcews_pkg::NODE_W-1:0] n);
    logic [kcews_pkg::NODE_W-1:0] r;
    logic [kcews_pkg::NODE_W-1:0] nxt;
    r = n;
    while (up_link[r] != r) r = up_link[r];
    while (n != r) begin
      nxt = up_link[n];
      up_link[n] = r;
      n = nxt;
    end
    return r;
  endfunction

  // Every 10-bit index is below the node count, so no edge is ever ignored.
  function automatic cycle_result_t absorb_edge(edge_req_t e);
    cycle_result_t res;
    logic [kcews_pkg::NODE_W-1:0] ra;
    logic [kcews_pkg::NODE_W-1:0] rb;
    ra = root_of(e.a);
    rb = root_of(e.b);
    res.closed = (ra == rb);
    if (ra == rb) begin
      if (cycle_sum > kcews_pkg::TOTAL_MAX - kcews_pkg::TOTAL_W'(e.w))
        cycle_sum = kcews_pkg::TOTAL_MAX;
      else cycle_sum = cycle_sum + kcews_pkg::TOTAL_W'(e.w);
    end else if (comp_rank[ra] < comp_rank[rb]) begin
      up_link[ra] = rb;
    end else begin
      up_link[rb] = ra;
      if (comp_rank[ra] == comp_rank[rb] && comp_rank[ra] != kcews_pkg::RANK_MAX)
        comp_rank[ra] = comp_rank[ra] + kcews_pkg::RANK_W'(1);
    end
    res.total = cycle_sum;
    return res;
  endfunction

  initial begin
    for (int i = 0; i < kcews_pkg::NODES; i++) begin
      up_link[i]   = kcews_pkg::NODE_W'(i);
      comp_rank[i] = '0;
    end
    cycle_sum = '0;
  end

  // ---------------------------------------------------------------------------
  // Driver: one request per accepted push; gaps at random outside the steady
  // window. A request stays on the ports until the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    edge_req_t nxt;
    if (!rst_ni) begin
      push     <= 1'b0;
      node_a_i <= '0;
      node_b_i <= '0;
      weight_i <= '0;
    end else begin
      if (push && !full) begin
        cycle_results_q.push_back(absorb_edge('{a: node_a_i, b: node_b_i, w: weight_i}));
        n_taken <= n_taken + 1;
      end
      if (!push || !full) begin
        if (edge_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = edge_q.pop_front();
          push     <= 1'b1;
          node_a_i <= nxt.a;
          node_b_i <= nxt.b;
          weight_i <= nxt.w;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure on pop; every accepted result is compared
  // field by field with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    cycle_result_t exp_res;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cycle_results_q.size() == 0) begin
          $error("unexpected result: closed_cycle=%0b dropped_total=%h",
                 closed_cycle_o, dropped_total_o);
          n_errors++;
        end else begin
          exp_res = cycle_results_q.pop_front();
          if (closed_cycle_o !== exp_res.closed) begin
            $error("closed_cycle: expected %0b, got %0b", exp_res.closed, closed_cycle_o);
            n_errors++;
          end
          if (dropped_total_o !== exp_res.total) begin
            $error("dropped_total: expected %h, got %h", exp_res.total, dropped_total_o);
            n_errors++;
          end
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("FAIL kruskal_cycle_edge_weight_sum_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_edge(input int a, input int b,
                          input logic [kcews_pkg::WEIGHT_W-1:0] w);
    edge_q.push_back('{a: kcews_pkg::NODE_W'(a), b: kcews_pkg::NODE_W'(b), w: w});
  endtask

  // Descending weights with random steps; wraps back to the top when spent.
  function automatic logic [kcews_pkg::WEIGHT_W-1:0] next_weight();
    logic [kcews_pkg::WEIGHT_W-1:0] step;
    step = $urandom_range(0, 1 << 23);
    if (step > desc_weight) desc_weight = '1;
    else desc_weight = desc_weight - step;
    return desc_weight;
  endfunction

  // Sender holds off until every request is answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (edge_q.size() != 0 || push || cycle_results_q.size() != 0);
  endtask

  initial begin
    int n_rand;
    int k;
    int span;
    int base;
    int b;
    bit paused_mid;
    n_rand     = 0;
    paused_mid = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme indices and weights, self loops, zero weight, rank
    // ties and a cycle found at depth across merged trees.
    add_edge(0, 1023, 32'hFFFF_FFFF);      // merge the extreme nodes
    add_edge(1023, 0, 32'hFFFF_FFFF);      // closes a cycle, heaviest weight
    add_edge(0, 0, 32'h0000_0000);         // self loop, zero weight
    add_edge(1023, 1023, 32'hFFFF_0000);   // self loop on a joined node
    add_edge(1, 2, 32'hF000_0000);
    add_edge(2, 3, 32'hE000_0000);
    add_edge(3, 1, 32'hD000_0000);         // triangle closes
    add_edge(10'h155, 10'h2AA, 32'hAAAA_AAAA);
    add_edge(10'h2AA, 10'h155, 32'h5555_5555);
    add_edge(4, 5, 32'h4000_0000);
    add_edge(6, 7, 32'h3000_0000);
    add_edge(4, 6, 32'h2000_0000);         // equal ranks, rank grows
    add_edge(1, 4, 32'h1000_0000);
    add_edge(3, 7, 32'h0800_0000);         // leaves at depth, same root
    add_edge(512, 511, 32'h0000_0001);
    add_edge(511, 512, 32'h0000_0000);
    wait_drained();

    // Random: mostly binomial builds on aligned node blocks (deep trees),
    // then in-block probes that mostly close cycles; the rest is noise.
    while (n_rand < RANDOM_EDGES) begin
      k    = $urandom_range(3, 8);
      span = 1 << k;
      base = $urandom_range(0, kcews_pkg::NODES / span - 1) * span;
      if ($urandom_range(0, 9) < 7) begin
        for (int s = 1; s < span; s = s * 2) begin
          for (int i = 0; i < span; i = i + 2 * s) begin
            add_edge(base + i, base + i + s, next_weight());
            n_rand++;
          end
        end
        repeat ($urandom_range(4, 24)) begin
          // an occasional far endpoint joins blocks together
          b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, kcews_pkg::NODES - 1)
                                          : base + $urandom_range(0, span - 1);
          add_edge(base + $urandom_range(0, span - 1), b, next_weight());
          n_rand++;
        end
      end else begin
        repeat ($urandom_range(5, 30)) begin
          add_edge($urandom_range(0, kcews_pkg::NODES - 1),
                   $urandom_range(0, kcews_pkg::NODES - 1), $urandom());
          n_rand++;
        end
      end
      if (!paused_mid && n_rand >= RANDOM_EDGES / 2) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS kruskal_cycle_edge_weight_sum_top");
    end else begin
      $display("FAIL kruskal_cycle_edge_weight_sum_top");
    end
    $finish;
  end

endmodule
